// File: design/nmeaf_pkg.sv
`timescale 1ns / 1ps
// Shared constants and types for the NMEA sentence framer.
// No dependencies; used by the framer top level and its port checker.
package nmeaf_pkg;

	// Stream payload widths (whole bytes).
	localparam int S_TDATA_W = 24;	// in_byte[7:0], read_index[19:8]
	localparam int M_TDATA_W = 24;	// frame_length[12:0], read_byte[20:13]

	localparam int INDEX_W  = 12;
	localparam int LENGTH_W = 13;

	// Command carried in s_tuser.
	typedef enum logic {
		CMD_FEED = 1'b0,
		CMD_READ = 1'b1
	} cmd_t;

	// Characters that delimit a sentence.
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_G      = 8'h47;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_LF     = 8'h0A;

endpackage

// File: design/nmeaf_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module nmeaf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: design/nmea_sentence_framer.sv
`timescale 1ns / 1ps
// NMEA sentence framer top level: capture state, sentence buffer and result staging.
// Depends on nmeaf_pkg and nmeaf_ram.

// The framer takes one transfer per clock on the slave stream while stage 1 is
// empty or can advance. With s_tuser at feed, the byte in s_tdata[7:0] is
// framed: bytes are dropped until a '$', the next byte must be 'G', a later
// "$G" restarts the sentence, and a '\r' with a '*' three bytes before it
// (sentence longer than five bytes) completes it. The completion transfer on
// the master stream has m_tlast high and carries the frame length, which
// counts a trailing '\n' when the buffer had room for it. With s_tuser at
// read, s_tdata[19:8] selects a buffer position; the result carries that byte
// if it lies in the sentence being captured, or in the one just completed
// while no new sentence is open, and zero otherwise. Every transfer in gives
// exactly one transfer out. Throughput is one item per clock for any mix of
// feeds and reads while m_tready is high. A result passes through the
// registered read of the sentence buffer RAM, held in stage 1, then the output
// register. The output register and the stage in front of it form a two-entry
// queue, so a new item is taken while a finished result waits for m_tready.
// The buffer needs no clearing after reset, because only positions written in
// the current frame are returned; the block is ready once reset is released.
module nmea_sentence_framer #(
	parameter int BUFFER_BYTES = 4096
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// Slave stream.
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [nmeaf_pkg::S_TDATA_W-1:0]  s_tdata,	// in_byte[7:0], read_index[19:8]
	input  logic                             s_tuser,	// command[0]
	// Master stream.
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [nmeaf_pkg::M_TDATA_W-1:0]  m_tdata,	// frame_length[12:0], read_byte[20:13]
	output logic                             m_tlast	// frame_done
);

	// Address width of the buffer and width of a count that can reach its size.
	localparam int AW   = $clog2(BUFFER_BYTES);
	localparam int CNTW = $clog2(BUFFER_BYTES + 1);
	// Common width for comparing the 12-bit read index against counts.
	localparam int CMPW = (CNTW > nmeaf_pkg::INDEX_W) ? CNTW : nmeaf_pkg::INDEX_W;
	// Width used to fold a count into the 13-bit length field.
	localparam int LW   = (CNTW > nmeaf_pkg::LENGTH_W) ? CNTW : nmeaf_pkg::LENGTH_W;

	localparam logic [CNTW-1:0] FULL  = CNTW'(BUFFER_BYTES);
	localparam logic [CNTW-1:0] ONE   = CNTW'(1);
	localparam logic [CNTW-1:0] TWO   = CNTW'(2);
	localparam logic [CNTW-1:0] THREE = CNTW'(3);
	localparam logic [CNTW-1:0] FIVE  = CNTW'(5);

	// Input field unpacking.
	logic [7:0]                    in_byte;
	logic [nmeaf_pkg::INDEX_W-1:0] read_index;
	logic                          accept;
	logic                          feed;

	assign in_byte    = s_tdata[7:0];
	assign read_index = s_tdata[19:8];
	assign accept     = s_tvalid && s_tready;
	assign feed       = (nmeaf_pkg::cmd_t'(s_tuser) == nmeaf_pkg::CMD_FEED);

	// Capture state.
	logic [CNTW-1:0] fill_q;	// bytes in the open sentence, zero when none is open
	logic [CNTW-1:0] cmpl_q;	// length of the frame just completed
	logic            lf_q;		// the completed frame ends in an appended line feed
	logic [7:0]      rb0_q, rb1_q, rb2_q;	// last three stored bytes, newest first

	// Next-state logic for a feed.
	logic [CNTW-1:0] f0, f1, n_fill, fill_d, cmpl_d;
	logic            lf_d;
	logic            store;
	logic            done;
	logic            room;
	logic [LW-1:0]   len_w;

	always_comb begin
		f0     = (fill_q == FULL) ? '0 : fill_q;
		f1     = (f0 == ONE && in_byte != nmeaf_pkg::CH_G) ? '0 : f0;
		store  = (f1 != '0) || (in_byte == nmeaf_pkg::CH_DOLLAR);
		n_fill = f1 + ONE;
		room   = (n_fill < FULL);
		done   = 1'b0;
		fill_d = f1;
		cmpl_d = cmpl_q;
		lf_d   = lf_q;
		if (f1 == '0) begin
			cmpl_d = '0;
			lf_d   = 1'b0;
		end
		if (store) begin
			if (n_fill > THREE && in_byte == nmeaf_pkg::CH_G &&
				rb0_q == nmeaf_pkg::CH_DOLLAR) begin
				// A fresh "$G" inside the sentence starts it over.
				fill_d = TWO;
			end else if (n_fill > FIVE && in_byte == nmeaf_pkg::CH_CR &&
				rb2_q == nmeaf_pkg::CH_STAR) begin
				// The line feed is not written to the RAM; a read of its
				// position is answered from lf_q instead.
				done   = 1'b1;
				fill_d = '0;
				cmpl_d = room ? (n_fill + ONE) : n_fill;
				lf_d   = room;
			end else begin
				fill_d = n_fill;
			end
		end
		len_w = LW'(cmpl_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			cmpl_q <= '0;
			lf_q   <= 1'b0;
			rb0_q  <= '0;
			rb1_q  <= '0;
			rb2_q  <= '0;
		end else if (accept && feed) begin
			fill_q <= fill_d;
			cmpl_q <= cmpl_d;
			lf_q   <= lf_d;
			if (store) begin
				rb0_q <= in_byte;
				rb1_q <= rb0_q;
				rb2_q <= rb1_q;
			end
		end
	end

	// Read decode: which positions are readable right now.
	logic [CNTW-1:0] extent;
	logic [CNTW-1:0] lf_pos;
	logic [CMPW-1:0] idx_w;
	logic            in_range;
	logic            lf_hit;

	always_comb begin
		extent   = (fill_q != '0) ? fill_q : cmpl_q;
		lf_pos   = cmpl_q - ONE;
		idx_w    = CMPW'(read_index);
		in_range = (idx_w < CMPW'(extent));
		lf_hit   = (fill_q == '0) && lf_q && (idx_w == CMPW'(lf_pos));
	end

	// Sentence buffer: written by stored feed bytes, read by read commands.
	logic [7:0] ram_rdata;

	nmeaf_ram #(
		.WIDTH (8),
		.DEPTH (BUFFER_BYTES)
	) u_buf (
		.clk   (clk),
		.we    (accept && feed && store),
		.waddr (f1[AW-1:0]),
		.wdata (in_byte),
		.re    (accept && !feed),
		.raddr (idx_w[AW-1:0]),
		.rdata (ram_rdata)
	);

	// Stage 1: waits for the RAM read data. While it holds, no read is issued,
	// so ram_rdata stays put.
	logic                           valid_s1;
	logic                           rd_s1;
	logic                           range_s1;
	logic                           lfhit_s1;
	logic                           done_s1;
	logic [nmeaf_pkg::LENGTH_W-1:0] len_s1;

	// Output register.
	logic                           ovalid_q;
	logic                           olast_q;
	logic [nmeaf_pkg::LENGTH_W-1:0] olen_q;
	logic [7:0]                     obyte_q;

	logic advance;
	logic [7:0] byte_s1;

	assign advance  = valid_s1 && (!ovalid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_comb begin
		byte_s1 = 8'h00;
		if (rd_s1 && range_s1) begin
			byte_s1 = lfhit_s1 ? nmeaf_pkg::CH_LF : ram_rdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			ovalid_q <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				ovalid_q <= 1'b1;
			end else if (m_tready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rd_s1    <= !feed;
			range_s1 <= in_range;
			lfhit_s1 <= lf_hit;
			done_s1  <= feed && done;
			len_s1   <= (feed && done) ? len_w[nmeaf_pkg::LENGTH_W-1:0] : '0;
		end
		if (advance) begin
			olast_q <= done_s1;
			olen_q  <= len_s1;
			obyte_q <= byte_s1;
		end
	end

	assign m_tvalid = ovalid_q;
	assign m_tlast  = olast_q;
	assign m_tdata  = {{(nmeaf_pkg::M_TDATA_W - nmeaf_pkg::LENGTH_W - 8){1'b0}},
		obyte_q, olen_q};

endmodule

// File: design/nmeaf_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the NMEA sentence framer master stream, with its bind.
// Depends on nmeaf_pkg and the nmea_sentence_framer top level.
module nmeaf_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            m_tvalid,
	input logic                            m_tready,
	input logic [nmeaf_pkg::M_TDATA_W-1:0] m_tdata,
	input logic                            m_tlast
);

	logic [12:0] frame_length;
	logic [7:0]  read_byte;

	assign frame_length = m_tdata[12:0];
	assign read_byte    = m_tdata[20:13];

	// A stalled result holds.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("result changed while stalled");

	// Only a completion carries a length.
	a_len_only_done: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> frame_length == 13'd0)
		else $error("length without completion");

	// A completed sentence is at least six bytes.
	a_min_len: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> frame_length >= 13'd6)
		else $error("completed sentence too short");

	// A completion never carries read data.
	a_no_byte_on_done: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> read_byte == 8'h00)
		else $error("read data on a completion");

endmodule

bind nmea_sentence_framer nmeaf_checker u_nmeaf_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);
